// ----- rtl/sfxp_pkg.sv -----
// Package for the framed XOR packet parser core.
// Holds widths, reset values, register indexes and the result beat layout.
// No dependencies.
`default_nettype none

package sfxp_pkg;

  localparam int ByteW    = 8;
  localparam int LenW     = 5;
  localparam int CfgIdxW  = 2;
  localparam int TdataW   = 32;
  localparam int TuserW   = 8;

  // largest payload the hardware carries
  localparam logic [LenW-1:0] MaxPayload = 5'd16;
  // payload bytes kept for a status report
  localparam logic [LenW-1:0] HeadBytes  = 5'd3;
  localparam logic [LenW-1:0] StatusLen  = 5'd3;

  // register reset values
  localparam logic [ByteW-1:0] SyncFirstRst  = 8'hAA;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'h55;
  localparam logic [ByteW-1:0] StatusTypeRst = 8'h01;
  localparam logic [LenW-1:0]  MaxLengthRst  = 5'd16;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_STATUS_TYPE = 2'd2,
    REG_MAX_LENGTH  = 2'd3
  } cfg_reg_t;

  // result beat, fields listed from the highest bit down
  typedef struct packed {
    logic             status_valid;
    logic             led_on;
    logic             alarm_on;
    logic [ByteW-1:0] humidity;
    logic [ByteW-1:0] temperature;
    logic             status_updated;
    logic [LenW-1:0]  frame_size;
    logic             frame_good;
  } result_t;

  localparam int ResultW = $bits(result_t);

endpackage

`default_nettype wire

// ----- rtl/sync_framed_xor_packet_parser_core.sv -----
// Top level of the framed XOR packet parser core.
// Depends on sfxp_pkg for widths, register indexes and the result layout.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one received byte per
//   beat. The parser looks for: sync one, sync two, type, length, payload,
//   checksum (XOR of type, length and payload). At each checksum byte one
//   result beat leaves on the master stream: m_tdata holds the check flag,
//   length and the latched status; m_tuser holds the frame type.
//   Latency: the result beat is valid the cycle after the checksum byte is
//   accepted. Throughput: one byte per cycle while s_tready is high; the parser
//   state and the output register are updated by one pass of logic per accepted byte.
//   Stall: while a result waits in the output register and m_tready is low,
//   s_tready drops; a waiting result is taken and a new byte accepted in the
//   same cycle when m_tready is high.
//   Reset (rst, synchronous): parser waits for the first sync byte, status
//   latches clear, registers return to 0xAA, 0x55, 0x01 and 16.
//   Configuration: cfg_we writes cfg_data to register cfg_index at the clock
//   edge (0 sync one, 1 sync two, 2 status type, 3 max length); write only
//   while no frame is in progress.
`default_nettype none

module sync_framed_xor_packet_parser_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [sfxp_pkg::ByteW-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  // [0] frame_good, [5:1] frame_size, [6] status_updated, [14:7] temperature,
  // [22:15] humidity, [23] alarm_on, [24] led_on, [25] status_valid, rest 0
  output logic [sfxp_pkg::TdataW-1:0]      m_tdata,
  output logic [sfxp_pkg::TuserW-1:0]      m_tuser,   // [7:0] frame_kind
  input  wire logic                        cfg_we,
  input  wire logic [sfxp_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [sfxp_pkg::ByteW-1:0]  cfg_data
);
  import sfxp_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5
  } phase_t;

  // configuration registers
  logic [ByteW-1:0] sync_first, sync_second, status_type;
  logic [LenW-1:0]  max_length;

  // parser state
  phase_t           phase, phase_next;
  logic [ByteW-1:0] held_type, held_type_next;
  logic [LenW-1:0]  held_length, held_length_next;
  logic [LenW-1:0]  bytes_seen, bytes_seen_next;
  logic [ByteW-1:0] running_xor, running_xor_next;
  logic [ByteW-1:0] head0, head1, head2;

  // latched status
  logic [ByteW-1:0] lat_temp, lat_temp_next;
  logic [ByteW-1:0] lat_hum, lat_hum_next;
  logic             lat_alarm, lat_alarm_next;
  logic             lat_led, lat_led_next;
  logic             lat_valid, lat_valid_next;

  // output register
  result_t          res, res_next;
  logic [ByteW-1:0] res_kind;
  logic             emit;

  logic             accept;
  logic [LenW-1:0]  limit;
  logic [LenW-1:0]  seen_inc;
  logic             good, upd;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign limit    = (max_length > MaxPayload) ? MaxPayload : max_length;
  assign seen_inc = bytes_seen + LenW'(1);
  assign good     = (s_tdata == running_xor);
  assign upd      = good && (held_type == status_type) && (held_length == StatusLen);

  // work out the next parser state for the accepted byte
  always_comb begin
    phase_next       = phase;
    held_type_next   = held_type;
    held_length_next = held_length;
    bytes_seen_next  = bytes_seen;
    running_xor_next = running_xor;
    lat_temp_next    = lat_temp;
    lat_hum_next     = lat_hum;
    lat_alarm_next   = lat_alarm;
    lat_led_next     = lat_led;
    lat_valid_next   = lat_valid;
    emit             = 1'b0;
    case (phase)
      PH_SYNC1: begin
        if (s_tdata == sync_first) phase_next = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (s_tdata == sync_second) begin
          phase_next = PH_TYPE;
        end else if (s_tdata != sync_first) begin
          phase_next       = PH_SYNC1;
          held_length_next = '0;
          bytes_seen_next  = '0;
          running_xor_next = '0;
        end
      end
      PH_TYPE: begin
        held_type_next   = s_tdata;
        running_xor_next = s_tdata;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        if (s_tdata > {{(ByteW-LenW){1'b0}}, limit}) begin
          // oversize length: drop the frame silently
          phase_next       = PH_SYNC1;
          held_length_next = '0;
          bytes_seen_next  = '0;
          running_xor_next = '0;
        end else begin
          held_length_next = s_tdata[LenW-1:0];
          bytes_seen_next  = '0;
          running_xor_next = running_xor ^ s_tdata;
          phase_next       = (s_tdata == '0) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        running_xor_next = running_xor ^ s_tdata;
        bytes_seen_next  = seen_inc;
        if (seen_inc >= held_length) phase_next = PH_CHECK;
      end
      PH_CHECK: begin
        emit = 1'b1;
        if (upd) begin
          lat_temp_next  = head0;
          lat_hum_next   = head1;
          lat_alarm_next = head2[0];
          lat_led_next   = head2[1];
          lat_valid_next = 1'b1;
        end
        phase_next       = PH_SYNC1;
        held_length_next = '0;
        bytes_seen_next  = '0;
        running_xor_next = '0;
      end
      default: begin
        phase_next       = PH_SYNC1;
        held_length_next = '0;
        bytes_seen_next  = '0;
        running_xor_next = '0;
      end
    endcase
  end

  // assemble the result beat
  always_comb begin
    res_next.frame_good     = good;
    res_next.frame_size     = held_length;
    res_next.status_updated = upd;
    res_next.temperature    = lat_temp_next;
    res_next.humidity       = lat_hum_next;
    res_next.alarm_on       = lat_alarm_next;
    res_next.led_on         = lat_led_next;
    res_next.status_valid   = lat_valid_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SyncFirstRst;
      sync_second <= SyncSecondRst;
      status_type <= StatusTypeRst;
      max_length  <= MaxLengthRst;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        REG_STATUS_TYPE: status_type <= cfg_data;
        REG_MAX_LENGTH:  max_length  <= cfg_data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // advance parser state and latches on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC1;
      held_type   <= '0;
      held_length <= '0;
      bytes_seen  <= '0;
      running_xor <= '0;
      lat_temp    <= '0;
      lat_hum     <= '0;
      lat_alarm   <= 1'b0;
      lat_led     <= 1'b0;
      lat_valid   <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      bytes_seen  <= bytes_seen_next;
      running_xor <= running_xor_next;
      lat_temp    <= lat_temp_next;
      lat_hum     <= lat_hum_next;
      lat_alarm   <= lat_alarm_next;
      lat_led     <= lat_led_next;
      lat_valid   <= lat_valid_next;
    end
  end

  // store the first payload bytes
  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && bytes_seen < HeadBytes) begin
      case (bytes_seen[1:0])
        2'd0:    head0 <= s_tdata;
        2'd1:    head1 <= s_tdata;
        default: head2 <= s_tdata;
      endcase
    end
  end

  // output register: load on a checksum beat, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res      <= res_next;
      res_kind <= held_type;
    end
  end

  assign m_tdata = {{(TdataW-ResultW){1'b0}}, res};
  assign m_tuser = res_kind;

endmodule

`default_nettype wire
